### rtl/alu_with_condition_flags_unit_assert.svh
// Assertion macros for the ALU with condition flags.
`ifndef ALU_WITH_CONDITION_FLAGS_UNIT_ASSERT_SVH
`define ALU_WITH_CONDITION_FLAGS_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define AF_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define AF_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define AF_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define AF_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

### rtl/afu_pkg.sv
`timescale 1ns / 1ps
package afu_pkg;

    typedef enum logic [4:0] {
        OP_MOV = 5'd0, OP_ADD = 5'd1, OP_SUB = 5'd2, OP_MUL = 5'd3, OP_DIV = 5'd4,
        OP_CMP = 5'd5, OP_AND = 5'd6, OP_OR = 5'd7, OP_XOR = 5'd8, OP_SHL = 5'd9,
        OP_SHR = 5'd10, OP_SAR = 5'd11, OP_LDL = 5'd12, OP_LDH = 5'd13,
        OP_NOT = 5'd14, OP_JMP = 5'd15, OP_JZ = 5'd16, OP_JP = 5'd17, OP_JN = 5'd18,
        OP_JC = 5'd19, OP_JV = 5'd20, OP_JNP = 5'd21, OP_JNN = 5'd22,
        OP_JNZ = 5'd23, OP_STOP = 5'd24
    } t_op;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0, ERR_DIV_ZERO = 2'd1, ERR_UNDEF = 2'd2
    } t_err;

    localparam logic [3:0] FLAG_N = 4'b1000;
    localparam logic [3:0] FLAG_Z = 4'b0100;
    localparam logic [3:0] FLAG_C = 4'b0010;
    localparam logic [3:0] FLAG_V = 4'b0001;
    localparam logic [31:0] HI_MASK = 32'hFFFF_0000;

    typedef struct packed {
        logic [4:0]         cmd;
        logic signed [31:0] op_a;
        logic signed [31:0] op_b;
        logic [31:0]        instr_ptr;
    } t_in;

    typedef struct packed {
        logic signed [31:0] result;
        logic               write_result;
        logic signed [31:0] remainder;
        logic               write_remainder;
        logic               jump_taken;
        logic [31:0]        jump_target;
        logic               halt;
        logic [3:0]         flags;
        logic [1:0]         error;
    } t_out;

    // classified item handed from front to back
    typedef struct packed {
        t_op         op;
        logic        is_div;
        logic        is_jump;
        logic        undef;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] target;
    } t_dec;

    function automatic logic [3:0] nz_bits(input logic [31:0] r);
        nz_bits = (r == 32'd0) ? FLAG_Z : (r[31] ? FLAG_N : 4'd0);
    endfunction

endpackage

### rtl/alu_with_condition_flags_unit.sv
`timescale 1ns / 1ps
// Path: queue, then execute; mul passes S_PROD and S_MUL, div waits on the divider.
// Throughput: one item a cycle for simple operations while the output slot can take results;
// mul and div hold execute until done. The 32-step restoring divider sets the worst-case rate.
// Reset: synchronous active-low i_rst_n empties the queues and clears the NZCV flags.
module alu_with_condition_flags_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  afu_pkg::t_in  i_item,
    output logic          empty,
    input  logic          pop,
    output afu_pkg::t_out o_result
);
    import afu_pkg::*;

    logic w_valid, w_take;
    t_dec w_dec;

    // front end: decode and classify into a two-entry queue
    afu_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full), .i_in(i_item),
        .o_valid(w_valid), .i_take(w_take), .o_dec(w_dec)
    );

    // back end: execute with the flag register; output slot per transfer
    afu_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_valid), .o_take(w_take),
        .i_dec(w_dec), .o_empty(empty), .i_pop(pop), .o_out(o_result)
    );
endmodule

### rtl/afu_front.sv
`timescale 1ns / 1ps
module afu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  afu_pkg::t_in  i_in,
    output logic          o_valid,
    input  logic          i_take,
    output afu_pkg::t_dec o_dec
);
    import afu_pkg::*;

    // two-entry queue between decode and execute
    t_dec       r_mem [2];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    t_dec       w_dec;
    logic       w_wr, w_rd;

    always_comb begin
        w_dec.op      = t_op'(i_in.cmd);
        w_dec.is_div  = (i_in.cmd == OP_DIV);
        w_dec.is_jump = (i_in.cmd >= OP_JMP) && (i_in.cmd <= OP_JNZ);
        w_dec.undef   = (i_in.cmd > OP_STOP);
        w_dec.a       = i_in.op_a;
        w_dec.b       = i_in.op_b;
        w_dec.target  = (i_in.instr_ptr & HI_MASK) + i_in.op_a;
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_dec   = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_take && o_valid;

    always_comb begin
        n_wp  = r_wp ^ w_wr;
        n_rp  = r_rp ^ w_rd;
        n_cnt = r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= w_dec;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end
endmodule

### rtl/afu_divider.sv
`timescale 1ns / 1ps
module afu_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quo,
    output logic [31:0] o_rem
);
    // restoring division on magnitudes, one bit per cycle;
    // the answer is held until the next start
    logic [31:0] r_q, r_d;
    logic [32:0] r_r;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [32:0] w_sh, w_diff;

    assign w_sh   = {r_r[31:0], r_q[31]};
    assign w_diff = w_sh - {1'b0, r_d};
    assign o_done = r_busy && (r_cnt == 6'd0);
    assign o_quo  = r_q;
    assign o_rem  = r_r[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 6'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd32;
            r_q    <= i_num;
            r_d    <= i_den;
            r_r    <= 33'd0;
        end else if (r_busy && r_cnt != 6'd0) begin
            r_cnt <= r_cnt - 6'd1;
            if (!w_diff[32]) begin
                r_r <= w_diff;
                r_q <= {r_q[30:0], 1'b1};
            end else begin
                r_r <= w_sh;
                r_q <= {r_q[30:0], 1'b0};
            end
        end
    end
endmodule

### rtl/afu_back.sv
`timescale 1ns / 1ps
`include "alu_with_condition_flags_unit_assert.svh"
module afu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_take,
    input  afu_pkg::t_dec i_dec,
    output logic          o_empty,
    input  logic          i_pop,
    output afu_pkg::t_out o_out
);
    import afu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001, S_PROD = 4'b0010, S_MUL = 4'b0100, S_DIV = 4'b1000
    } t_state;

    t_state      r_state;
    logic [3:0]  r_flags;
    t_out        r_out;
    logic        r_full, n_full;
    logic [31:0] r_ma, r_mb;
    logic        r_sgn_q, r_sgn_r;
    logic [63:0] r_prod;
    t_out        w_res, w_mul_out, w_div_out, w_nxt;
    logic [3:0]  w_f;
    logic        w_free, w_go, w_div_start, w_div_done, w_load;
    logic [31:0] w_quo, w_rem, w_q, w_r, w_ma, w_mb, w_nb, w_s, w_mul_res;
    logic        w_jt, w_held, w_rem_ok;

    assign w_free = !r_full || i_pop;
    assign w_go   = (r_state == S_IDLE) && i_valid;
    assign w_ma   = i_dec.a[31] ? (32'd0 - i_dec.a) : i_dec.a;
    assign w_mb   = i_dec.b[31] ? (32'd0 - i_dec.b) : i_dec.b;
    assign w_div_start = w_go && i_dec.is_div && (i_dec.b != 32'd0);

    afu_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(w_ma), .i_den(w_mb), .o_done(w_div_done), .o_quo(w_quo), .o_rem(w_rem)
    );

    assign w_q = r_sgn_q ? (32'd0 - w_quo) : w_quo;
    assign w_r = r_sgn_r ? (32'd0 - w_rem) : w_rem;
    // low word of the signed product from the magnitude product
    assign w_mul_res = r_sgn_q ? (32'd0 - r_prod[31:0]) : r_prod[31:0];

    function automatic logic [3:0] sum_f(input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] s);
        logic [32:0] ex;
        logic [3:0]  f;
        ex = {a[31], a} + {b[31], b};
        f  = nz_bits(s);
        if (ex[32]) f = f | FLAG_C;
        if (!a[31] && a != 0 && !b[31] && b != 0 && (s[31] || s == 0)) f = f | FLAG_V;
        if (a[31] && b[31] && !s[31]) f = f | FLAG_V;
        sum_f = f;
    endfunction

    // combinational results of the simple operations
    always_comb begin
        w_res = '0;
        w_f   = r_flags;
        w_nb  = 32'd0 - i_dec.b;
        w_s   = 32'd0;
        w_jt  = 1'b0;
        unique case (i_dec.op)
            OP_MOV: begin w_s = i_dec.b; w_f = nz_bits(w_s); end
            OP_ADD: begin w_s = i_dec.a + i_dec.b; w_f = sum_f(i_dec.a, i_dec.b, w_s); end
            OP_SUB, OP_CMP: begin
                w_s = i_dec.a - i_dec.b; w_f = sum_f(i_dec.a, w_nb, w_s);
            end
            OP_AND: begin w_s = i_dec.a & i_dec.b; w_f = nz_bits(w_s); end
            OP_OR:  begin w_s = i_dec.a | i_dec.b; w_f = nz_bits(w_s); end
            OP_XOR: begin w_s = i_dec.a ^ i_dec.b; w_f = nz_bits(w_s); end
            OP_SHL: begin
                w_s = (i_dec.b < 32) ? (i_dec.a << i_dec.b[4:0]) : 32'd0;
                w_f = nz_bits(w_s);
                if ((w_s & HI_MASK) != 0) w_f = w_f | FLAG_C;
                if (!i_dec.a[31] && i_dec.a != 0 && w_s[31]) w_f = w_f | FLAG_V;
                if (i_dec.a[31] && !w_s[31] && w_s != 0) w_f = w_f | FLAG_V;
            end
            OP_SHR: begin
                w_s = (i_dec.b < 32) ? (i_dec.a >> i_dec.b[4:0]) : 32'd0;
                w_f = nz_bits(w_s) | (i_dec.a[31] ? FLAG_V : 4'd0);
            end
            OP_SAR: begin
                w_s = (i_dec.b < 32) ? 32'($signed(i_dec.a) >>> i_dec.b[4:0])
                                     : {32{i_dec.a[31]}};
                w_f = nz_bits(w_s);
            end
            OP_LDL: begin
                w_s = (i_dec.a & HI_MASK) | (i_dec.b & ~HI_MASK); w_f = nz_bits(w_s);
            end
            OP_LDH: begin
                w_s = (i_dec.a & ~HI_MASK) | {i_dec.b[15:0], 16'd0}; w_f = nz_bits(w_s);
            end
            OP_NOT: begin w_s = ~i_dec.a; w_f = nz_bits(w_s); end
            OP_JMP: w_jt = 1'b1;
            OP_JZ:  w_jt = r_flags[2];
            OP_JP:  w_jt = !r_flags[3] && !r_flags[2];
            OP_JN:  w_jt = r_flags[3];
            OP_JC:  w_jt = r_flags[1];
            OP_JV:  w_jt = r_flags[0];
            OP_JNP: w_jt = r_flags[3] || r_flags[2];
            OP_JNN: w_jt = !r_flags[3];
            OP_JNZ: w_jt = !r_flags[2];
            default: ;
        endcase
        w_res.result       = w_s;
        w_res.write_result = !i_dec.is_jump && !i_dec.undef && (i_dec.op != OP_CMP)
                             && (i_dec.op != OP_STOP) && !i_dec.is_div;
        if (!w_res.write_result) w_res.result = '0;
        w_res.jump_taken  = i_dec.is_jump && w_jt;
        w_res.jump_target = i_dec.is_jump ? i_dec.target : 32'd0;
        w_res.halt        = (i_dec.op == OP_STOP);
        w_res.error       = i_dec.undef ? ERR_UNDEF : ERR_NONE;
        w_res.flags       = w_f;
        if (i_dec.is_div) begin
            w_res.flags = r_flags;
            w_res.error = ERR_DIV_ZERO;
        end
    end

    // results of the multi-cycle operations and what goes into the output slot
    always_comb begin
        w_mul_out = '0;
        w_mul_out.result       = w_mul_res;
        w_mul_out.write_result = 1'b1;
        w_mul_out.flags        = nz_bits(w_mul_res)
                                 | ((r_prod[63:32] != 32'd0) ? (FLAG_C | FLAG_V) : 4'd0);
        w_div_out = '0;
        w_div_out.result          = w_q;
        w_div_out.write_result    = 1'b1;
        w_div_out.remainder       = w_r;
        w_div_out.write_remainder = 1'b1;
        w_div_out.flags           = nz_bits(w_q);
        w_load = 1'b0;
        w_nxt  = w_res;
        unique case (r_state)
            S_IDLE: w_load = o_take && (i_dec.op != OP_MUL) && !w_div_start;
            S_MUL: begin
                w_load = w_free;
                w_nxt  = w_mul_out;
            end
            S_DIV: begin
                w_load = w_div_done && w_free;
                w_nxt  = w_div_out;
            end
            default: ;
        endcase
        n_full = w_load || (r_full && !i_pop);
    end

    // take a new item when the output slot can hold its result, or at once for mul and for a div by a nonzero divisor
    assign o_take  = w_go && (w_free || i_dec.op == OP_MUL
                     || (i_dec.is_div && i_dec.b != 0));
    assign o_empty = !r_full;
    assign o_out   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_flags <= 4'd0;
            r_full  <= 1'b0;
        end else begin
            r_full <= n_full;
            if (w_load) begin
                r_out   <= w_nxt;
                r_flags <= w_nxt.flags;
            end
            unique case (r_state)
                S_IDLE: if (o_take) begin
                    r_ma <= w_ma;
                    r_mb <= w_mb;
                    r_sgn_q <= i_dec.a[31] ^ i_dec.b[31];
                    r_sgn_r <= i_dec.a[31];
                    if (i_dec.op == OP_MUL) begin
                        r_state <= S_PROD;
                    end else if (w_div_start) begin
                        r_state <= S_DIV;
                    end
                end
                // product register settles in this cycle
                S_PROD: r_state <= S_MUL;
                S_MUL: if (w_free) begin
                    r_state <= S_IDLE;
                end
                S_DIV: if (w_div_done && w_free) begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // magnitude product registered ahead of the flag check
    always_ff @(posedge i_clk) begin
        r_prod <= r_ma * r_mb;
    end

    assign w_held   = (r_state != S_IDLE) || r_full;
    assign w_rem_ok = !r_full || !r_out.write_remainder || r_out.write_result;

    `AF_ASSERT_NEXT(a_take_idle, i_clk, i_rst_n, o_take, w_held, "take lost")
    `AF_ASSERT_IMPL(a_onehot, i_clk, i_rst_n, $onehot(r_state), "state not one-hot")
    `AF_ASSERT_IMPL(a_wrem, i_clk, i_rst_n, w_rem_ok, "rem without quotient")
endmodule
